@@ design/hbtd_pkg.sv @@
// ----------------------------------------------------------------------------
// HTTP body transfer decoder package
// Shared types and register indexes for the body transfer decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package hbtd_pkg;

  typedef logic [7:0] byte_t;

  typedef logic [0:0] cfg_index_t;

  localparam int unsigned CfgDataW = 32;

  localparam cfg_index_t CfgCodingMode = 1'b0;
  localparam cfg_index_t CfgBodyLength = 1'b1;

  localparam logic [7:0] ChCr   = 8'h0D;
  localparam logic [7:0] ChLf   = 8'h0A;
  localparam logic [7:0] ChSemi = 8'h3B;

endpackage

`default_nettype wire

@@ design/hbtd_if.sv @@
// ----------------------------------------------------------------------------
// HTTP body transfer decoder channels
// Valid/ready channels for raw body bytes in and classified bytes out.
// ----------------------------------------------------------------------------
`default_nettype none

interface hbtd_in_if;
  logic            valid;
  logic            ready;
  hbtd_pkg::byte_t body_byte;

  modport source (output valid, output body_byte, input ready);
  modport sink   (input valid, input body_byte, output ready);
endinterface

interface hbtd_out_if;
  logic            valid;
  logic            ready;
  hbtd_pkg::byte_t payload_byte;
  logic            is_payload;
  logic            body_end;
  logic            framing_error;

  modport source (
    output valid, output payload_byte, output is_payload,
    output body_end, output framing_error, input ready
  );
  modport sink (
    input valid, input payload_byte, input is_payload,
    input body_end, input framing_error, output ready
  );
endinterface

`default_nettype wire

@@ design/http_body_transfer_decoder.sv @@
// ----------------------------------------------------------------------------
// HTTP body transfer decoder
// Classifies entity-body bytes as payload, flags body end and framing errors.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries one raw body byte per transfer. out_ch returns one transfer
//   per input byte: the byte itself, is_payload, body_end and framing_error.
//   The configuration port writes coding_mode (index 0) or body_length
//   (index 1); any write restarts the decoder. Write only while idle.
//   Identity mode marks the first body_length bytes as payload. Chunked mode
//   runs a 14-phase parser over size line, extensions, data, CRLFs, last
//   chunk and trailers; an errored byte leaves the parser state as it was.
//   Output: registered, valid in the cycle after the input transfer.
//   Throughput: one byte per cycle unless out_ch stalls, set by the single
//   output register; the parser step (hex shift, counter add, compare) is
//   combinational. Reset: identity mode, body_length zero, parser at chunk
//   size, output empty.
//   Stall: while out_ch is stalled, the result holds and in_ch takes no new
//   byte; in_ch.ready follows out_ch.ready combinationally.
// ----------------------------------------------------------------------------
`default_nettype none

module http_body_transfer_decoder #(
  parameter int unsigned SIZE_BITS = 32
) (
  input  wire                                clk_i,
  input  wire                                rst_ni,
  hbtd_in_if.sink                            in_ch,
  hbtd_out_if.source                         out_ch,
  input  wire                                cfg_we_i,
  input  wire hbtd_pkg::cfg_index_t          cfg_index_i,
  input  wire [hbtd_pkg::CfgDataW-1:0]       cfg_data_i
);

  localparam int unsigned CntW = (SIZE_BITS > 32) ? SIZE_BITS : 32;

  localparam logic [3:0] PhSize        = 4'd0;
  localparam logic [3:0] PhSizeCr      = 4'd1;
  localparam logic [3:0] PhData        = 4'd2;
  localparam logic [3:0] PhDataEnd     = 4'd3;
  localparam logic [3:0] PhDataEndCr   = 4'd4;
  localparam logic [3:0] PhExt         = 4'd5;
  localparam logic [3:0] PhExtCr       = 4'd6;
  localparam logic [3:0] PhLastExt     = 4'd7;
  localparam logic [3:0] PhLastExtCr   = 4'd8;
  localparam logic [3:0] PhAfter       = 4'd9;
  localparam logic [3:0] PhAfterCr     = 4'd10;
  localparam logic [3:0] PhTrailer     = 4'd11;
  localparam logic [3:0] PhTrailerCr   = 4'd12;
  localparam logic [3:0] PhEnd         = 4'd13;

  logic                   mode_q;
  logic [31:0]            len_q;
  logic [3:0]             phase_q, phase_d;
  logic [SIZE_BITS-1:0]   size_q, size_d;
  logic [CntW-1:0]        cnt_q, cnt_d;

  logic                   out_valid_q;
  hbtd_pkg::byte_t        out_byte_q;
  logic                   out_pay_q, out_end_q, out_err_q;

  logic                   in_fire;
  hbtd_pkg::byte_t        c;
  logic                   hex_ok;
  logic [3:0]             hex_val;
  logic                   size_zero;
  logic [SIZE_BITS-1:0]   cnt_inc;
  logic                   pay, body_end, err;

  assign in_ch.ready = !out_valid_q || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;
  assign c           = in_ch.body_byte;
  assign size_zero   = (size_q == '0);
  assign cnt_inc     = cnt_q[SIZE_BITS-1:0] + SIZE_BITS'(1);

  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    case (c) inside
      [8'h30:8'h39]: hex_val = c[3:0];
      [8'h61:8'h66],
      [8'h41:8'h46]: hex_val = c[3:0] + 4'd9;
      default:       hex_ok  = 1'b0;
    endcase
  end

  always_comb begin
    phase_d  = phase_q;
    size_d   = size_q;
    cnt_d    = cnt_q;
    pay      = 1'b0;
    body_end = 1'b0;
    err      = 1'b0;
    if (!mode_q) begin
      if (cnt_q < CntW'(len_q)) begin
        cnt_d = cnt_q + CntW'(1);
        pay   = 1'b1;
      end
      body_end = (cnt_d >= CntW'(len_q));
    end else begin
      case (phase_q)
        PhSize: begin
          if (hex_ok) begin
            if (size_q[SIZE_BITS-1 -: 4] != 4'd0) begin
              err = 1'b1;
            end else begin
              size_d = {size_q[SIZE_BITS-5:0], hex_val};
            end
          end else if (c == hbtd_pkg::ChSemi) begin
            phase_d = size_zero ? PhLastExt : PhExt;
          end else if (c == hbtd_pkg::ChCr) begin
            phase_d = PhSizeCr;
          end else begin
            err = 1'b1;
          end
        end
        PhSizeCr: begin
          if (c != hbtd_pkg::ChLf) begin
            err = 1'b1;
          end else if (size_zero) begin
            phase_d = PhAfter;
          end else begin
            phase_d = PhData;
            cnt_d   = '0;
          end
        end
        PhData: begin
          cnt_d = CntW'(cnt_inc);
          if (cnt_inc == size_q) begin
            phase_d = PhDataEnd;
          end
          pay = 1'b1;
        end
        PhDataEnd: begin
          if (c != hbtd_pkg::ChCr) begin
            err = 1'b1;
          end else begin
            phase_d = PhDataEndCr;
          end
        end
        PhDataEndCr: begin
          if (c != hbtd_pkg::ChLf) begin
            err = 1'b1;
          end else begin
            phase_d = PhSize;
            size_d  = '0;
          end
        end
        PhExt: begin
          if (c == hbtd_pkg::ChCr) begin
            phase_d = PhExtCr;
          end
        end
        PhExtCr: begin
          if (c == hbtd_pkg::ChLf) begin
            phase_d = PhData;
            cnt_d   = '0;
          end
        end
        PhLastExt: begin
          if (c == hbtd_pkg::ChCr) begin
            phase_d = PhLastExtCr;
          end
        end
        PhLastExtCr, PhTrailerCr: begin
          if (c != hbtd_pkg::ChLf) begin
            err = 1'b1;
          end else begin
            phase_d = PhAfter;
            cnt_d   = '0;
          end
        end
        PhAfter: begin
          phase_d = (c == hbtd_pkg::ChCr) ? PhAfterCr : PhTrailer;
        end
        PhAfterCr: begin
          if (c != hbtd_pkg::ChLf) begin
            err = 1'b1;
          end else begin
            phase_d  = PhEnd;
            body_end = 1'b1;
          end
        end
        PhTrailer: begin
          if (c == hbtd_pkg::ChCr) begin
            phase_d = PhTrailerCr;
          end
        end
        PhEnd: begin
          body_end = 1'b1;
        end
        default: begin
          err = 1'b1;
        end
      endcase
      if (err) begin
        phase_d = phase_q;
        size_d  = size_q;
        cnt_d   = cnt_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      len_q   <= '0;
      phase_q <= PhSize;
      size_q  <= '0;
      cnt_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        hbtd_pkg::CfgCodingMode: mode_q <= cfg_data_i[0];
        hbtd_pkg::CfgBodyLength: len_q  <= cfg_data_i;
        default: ;
      endcase
      phase_q <= PhSize;
      size_q  <= '0;
      cnt_q   <= '0;
    end else if (in_fire) begin
      phase_q <= phase_d;
      size_q  <= size_d;
      cnt_q   <= cnt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_byte_q <= c;
      out_pay_q  <= pay;
      out_end_q  <= body_end;
      out_err_q  <= err;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.payload_byte  = out_byte_q;
  assign out_ch.is_payload    = out_pay_q;
  assign out_ch.body_end      = out_end_q;
  assign out_ch.framing_error = out_err_q;

endmodule

`default_nettype wire

@@ design/hbtd_checker.sv @@
// ----------------------------------------------------------------------------
// HTTP body transfer decoder checker
// Port-level assertions on the decoder, attached by bind.
// ----------------------------------------------------------------------------
`default_nettype none

module hbtd_port_checker (
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   in_valid_i,
  input wire                   in_ready_i,
  input wire                   out_valid_i,
  input wire                   out_ready_i,
  input wire hbtd_pkg::byte_t  payload_byte_i,
  input wire                   is_payload_i,
  input wire                   body_end_i,
  input wire                   framing_error_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(payload_byte_i)
      && $stable(is_payload_i) && $stable(body_end_i) && $stable(framing_error_i))
    else $error("stalled output transfer changed");

  a_in_gives_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i |=> out_valid_i)
    else $error("accepted byte produced no result");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_i || out_ready_i |-> in_ready_i)
    else $error("input stalled with room for a result");

  a_err_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && framing_error_i |-> !is_payload_i && !body_end_i)
    else $error("framing error with payload or end flag");

endmodule

bind http_body_transfer_decoder hbtd_port_checker u_hbtd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_ch.valid),
  .in_ready_i      (in_ch.ready),
  .out_valid_i     (out_ch.valid),
  .out_ready_i     (out_ch.ready),
  .payload_byte_i  (out_ch.payload_byte),
  .is_payload_i    (out_ch.is_payload),
  .body_end_i      (out_ch.body_end),
  .framing_error_i (out_ch.framing_error)
);

`default_nettype wire

@@ tb/sv/hbtd_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTTP body transfer decoder checker
// Watches the byte channels and the configuration port, predicts the
// classification of every accepted body byte and compares each returned
// transfer field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module hbtd_checker
  import hbtd_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  hbtd_in_if                  in_mon,
  hbtd_out_if                 out_mon,
  input  logic                cfg_we_i,
  input  cfg_index_t          cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  output logic [31:0]         fail_count_o,
  output logic [31:0]         pending_o
);

  localparam int SizeBits = 32;

  typedef enum logic [3:0] {
    PhSize,
    PhSizeCr,
    PhData,
    PhDataEnd,
    PhDataEndCr,
    PhExt,
    PhExtCr,
    PhLastExt,
    PhLastExtCr,
    PhAfter,
    PhAfterCr,
    PhTrailer,
    PhTrailerCr,
    PhEnd
  } phase_e;

  typedef struct packed {
    byte_t payload_byte;
    logic  is_payload;
    logic  body_end;
    logic  framing_error;
  } result_t;

  logic                chunked;
  logic [31:0]         content_len;
  phase_e              chunk_phase;
  logic [SizeBits-1:0] chunk_len;
  logic [SizeBits-1:0] byte_count;
  result_t             predicted_q[$];
  int                  fails;

  function automatic logic [4:0] hex_digit(byte_t c);
    if (c >= 8'h30 && c <= 8'h39) return {1'b1, 4'(c - 8'h30)};
    if (c >= 8'h61 && c <= 8'h66) return {1'b1, 4'(c - 8'h57)};
    if (c >= 8'h41 && c <= 8'h46) return {1'b1, 4'(c - 8'h37)};
    return 5'b0;
  endfunction

  function automatic void restart_decoder();
    chunk_phase = PhSize;
    chunk_len   = '0;
    byte_count  = '0;
  endfunction

  function automatic result_t classify_byte(byte_t c);
    result_t    r;
    logic [4:0] dv;
    r = '{payload_byte: c, is_payload: 1'b0, body_end: 1'b0, framing_error: 1'b0};
    if (!chunked) begin
      if (byte_count < content_len) begin
        byte_count++;
        r.is_payload = 1'b1;
      end
      r.body_end = (byte_count >= content_len);
    end else begin
      case (chunk_phase)
        PhSize: begin
          dv = hex_digit(c);
          if (dv[4]) begin
            if (chunk_len[SizeBits-1 -: 4] != '0) begin
              r.framing_error = 1'b1;
            end else begin
              chunk_len = {chunk_len[SizeBits-5:0], dv[3:0]};
            end
          end else if (c == ChSemi) begin
            chunk_phase = (chunk_len == '0) ? PhLastExt : PhExt;
          end else if (c == ChCr) begin
            chunk_phase = PhSizeCr;
          end else begin
            r.framing_error = 1'b1;
          end
        end
        PhSizeCr: begin
          if (c != ChLf) begin
            r.framing_error = 1'b1;
          end else if (chunk_len == '0) begin
            chunk_phase = PhAfter;
          end else begin
            chunk_phase = PhData;
            byte_count  = '0;
          end
        end
        PhData: begin
          byte_count = byte_count + 1'b1;
          if (byte_count == chunk_len) chunk_phase = PhDataEnd;
          r.is_payload = 1'b1;
        end
        PhDataEnd: begin
          if (c != ChCr) r.framing_error = 1'b1;
          else chunk_phase = PhDataEndCr;
        end
        PhDataEndCr: begin
          if (c != ChLf) begin
            r.framing_error = 1'b1;
          end else begin
            chunk_phase = PhSize;
            chunk_len   = '0;
          end
        end
        PhExt: begin
          if (c == ChCr) chunk_phase = PhExtCr;
        end
        PhExtCr: begin
          if (c == ChLf) begin
            chunk_phase = PhData;
            byte_count  = '0;
          end
        end
        PhLastExt: begin
          if (c == ChCr) chunk_phase = PhLastExtCr;
        end
        PhLastExtCr: begin
          if (c != ChLf) begin
            r.framing_error = 1'b1;
          end else begin
            chunk_phase = PhAfter;
            byte_count  = '0;
          end
        end
        PhAfter: begin
          chunk_phase = (c == ChCr) ? PhAfterCr : PhTrailer;
        end
        PhAfterCr: begin
          if (c != ChLf) begin
            r.framing_error = 1'b1;
          end else begin
            chunk_phase = PhEnd;
            r.body_end  = 1'b1;
          end
        end
        PhTrailer: begin
          if (c == ChCr) chunk_phase = PhTrailerCr;
        end
        PhTrailerCr: begin
          if (c != ChLf) begin
            r.framing_error = 1'b1;
          end else begin
            chunk_phase = PhAfter;
            byte_count  = '0;
          end
        end
        PhEnd: begin
          r.body_end = 1'b1;
        end
        default: begin
          r.framing_error = 1'b1;
        end
      endcase
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      chunked     = 1'b0;
      content_len = '0;
      restart_decoder();
      predicted_q.delete();
      fails = 0;
      fail_count_o <= '0;
      pending_o    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          CfgCodingMode: chunked = cfg_data_i[0];
          CfgBodyLength: content_len = cfg_data_i[31:0];
          default: ;
        endcase
        restart_decoder();
      end
      if (in_mon.valid && in_mon.ready) begin
        predicted_q.push_back(classify_byte(in_mon.body_byte));
      end
      if (out_mon.valid && out_mon.ready) begin
        if (predicted_q.size() == 0) begin
          $error("unexpected transfer: payload_byte %0h", out_mon.payload_byte);
          fails++;
        end else begin
          want = predicted_q.pop_front();
          if (out_mon.payload_byte !== want.payload_byte) begin
            $error("payload_byte mismatch: expected %0h actual %0h",
                   want.payload_byte, out_mon.payload_byte);
            fails++;
          end
          if (out_mon.is_payload !== want.is_payload) begin
            $error("is_payload mismatch: expected %0b actual %0b",
                   want.is_payload, out_mon.is_payload);
            fails++;
          end
          if (out_mon.body_end !== want.body_end) begin
            $error("body_end mismatch: expected %0b actual %0b",
                   want.body_end, out_mon.body_end);
            fails++;
          end
          if (out_mon.framing_error !== want.framing_error) begin
            $error("framing_error mismatch: expected %0b actual %0b",
                   want.framing_error, out_mon.framing_error);
            fails++;
          end
        end
      end
      fail_count_o <= fails;
      pending_o    <= predicted_q.size();
    end
  end

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// HTTP body transfer decoder testbench
// Drives identity and chunked bodies through the decoder: a directed pass
// over length extremes and framing corners, then random chunked
// messages, broken messages, noise and large or oversized chunk sizes, with
// random stalls on both channels. The checker predicts and compares.
// ----------------------------------------------------------------------------
module tb;
  import hbtd_pkg::*;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  cfg_index_t          cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;
  logic [31:0]         fail_count;
  logic [31:0]         pending;
  bit                  calm;
  byte_t               body_q[$];
  int                  random_sent;

  hbtd_in_if  in_ch();
  hbtd_out_if out_ch();

  http_body_transfer_decoder #(
    .SIZE_BITS(32)
  ) u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_ch      (in_ch),
    .out_ch     (out_ch),
    .cfg_we_i   (cfg_we_i),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i (cfg_data_i)
  );

  hbtd_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch),
    .out_mon     (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  function automatic int idle_len();
    if ($urandom_range(0, 9) < 7) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic byte_t byte_other_than(byte_t x);
    byte_t b;
    do b = byte_t'($urandom); while (b == x);
    return b;
  endfunction

  function automatic byte_t noise_byte();
    byte_t picks[10] = '{ChCr, ChLf, ChSemi, 8'h30, 8'h66, 8'h46,
                         8'h67, 8'h47, 8'h3A, 8'h2F};
    if ($urandom_range(0, 9) < 4) return picks[$urandom_range(0, 9)];
    return byte_t'($urandom);
  endfunction

  function automatic byte_t hex_char(logic [3:0] n, bit upper);
    if (n < 4'd10) return 8'h30 + n;
    return (upper ? 8'h37 : 8'h57) + n;
  endfunction

  function automatic void push_hex(logic [31:0] v, int min_digits);
    int digits;
    digits = 0;
    for (int i = 0; i < 8; i++) begin
      if (((v >> (4 * i)) & 32'hF) != 0) digits = i + 1;
    end
    if (digits < min_digits) digits = min_digits;
    for (int i = digits - 1; i >= 0; i--) begin
      body_q.push_back(hex_char(4'((v >> (4 * i)) & 32'hF), $urandom_range(0, 1)));
    end
  endfunction

  function automatic void push_crlf();
    body_q.push_back(ChCr);
    body_q.push_back(ChLf);
  endfunction

  function automatic void push_random(int n);
    repeat (n) body_q.push_back(byte_t'($urandom));
  endfunction

  function automatic void build_chunked(bit clean);
    int len;
    int pos;
    repeat ($urandom_range(0, 3)) begin
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      push_hex(len, $urandom_range(0, 2));
      if ($urandom_range(0, 3) == 0) begin
        body_q.push_back(ChSemi);
        repeat ($urandom_range(0, 4)) body_q.push_back(byte_other_than(ChCr));
        if ($urandom_range(0, 1)) begin
          body_q.push_back(ChCr);
          repeat ($urandom_range(1, 2)) body_q.push_back(byte_other_than(ChLf));
        end
      end
      push_crlf();
      push_random(len);
      push_crlf();
    end
    case ($urandom_range(0, 2))
      0: ;
      1: body_q.push_back(8'h30);
      default: push_hex(0, $urandom_range(2, 3));
    endcase
    if ($urandom_range(0, 3) == 0) begin
      body_q.push_back(ChSemi);
      repeat ($urandom_range(0, 4)) body_q.push_back(byte_other_than(ChCr));
    end
    push_crlf();
    repeat ($urandom_range(0, 2)) begin
      body_q.push_back(byte_other_than(ChCr));
      repeat ($urandom_range(0, 5)) body_q.push_back(byte_other_than(ChCr));
      push_crlf();
    end
    push_crlf();
    push_random($urandom_range(0, 3));
    if (!clean) begin
      repeat ($urandom_range(1, 3)) begin
        pos = $urandom_range(0, body_q.size());
        body_q.insert(pos, noise_byte());
      end
    end
  endfunction

  task automatic send_byte(input byte_t b);
    int gap;
    gap = (calm || $urandom_range(0, 1)) ? 0 : idle_len();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_ch.valid     <= 1'b1;
    in_ch.body_byte <= b;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic send_queue();
    while (body_q.size() > 0) send_byte(body_q.pop_front());
  endtask

  // drain every outstanding transfer before touching the registers
  task automatic settle();
    in_ch.valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CfgDataW-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    int hold;
    hold = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold > 0) begin
        hold--;
      end else if (calm || $urandom_range(0, 2) != 0) begin
        out_ch.ready <= 1'b1;
        hold = $urandom_range(0, 12);
      end else begin
        out_ch.ready <= 1'b0;
        hold = idle_len() - 1;
      end
    end
  end

  initial begin
    int          kind;
    int          pick;
    logic [31:0] len;
    in_ch.valid     <= 1'b0;
    in_ch.body_byte <= '0;
    cfg_we_i        <= 1'b0;
    cfg_index_i     <= CfgCodingMode;
    cfg_data_i      <= '0;
    rst_ni          <= 1'b0;
    calm        = 1'b0;
    random_sent = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    write_reg(CfgCodingMode, '0);
    write_reg(CfgBodyLength, '0);
    send_byte(8'h00);
    settle();
    write_reg(CfgBodyLength, 32'hFFFF_FFFF);
    send_byte(8'hFF);
    settle();

    write_reg(CfgCodingMode, {31'h7FFF_FFFF, 1'b1});
    body_q = {8'h47, 8'h31, ChSemi, ChCr, 8'h71, ChLf, 8'hFF, 8'h78, ChCr, 8'h78,
              ChLf, 8'h30, ChSemi, ChCr, 8'h78, ChLf, 8'h54, ChCr, 8'h78, ChLf,
              ChCr, 8'h78, ChLf, 8'h41};
    send_queue();

    while (random_sent < 1200) begin
      settle();
      calm = ($urandom_range(0, 4) == 0);
      kind = $urandom_range(0, 99);
      if (kind < 25 || kind >= 96) begin
        pick = $urandom_range(0, 9);
        if (kind >= 96 || pick == 9) len = $urandom;
        else if (pick < 3) len = $urandom_range(0, 3);
        else len = $urandom_range(4, 40);
        if ($urandom_range(0, 1)) begin
          write_reg(CfgCodingMode, {31'($urandom), 1'b0});
          write_reg(CfgBodyLength, len);
        end else begin
          write_reg(CfgBodyLength, len);
          write_reg(CfgCodingMode, {31'($urandom), 1'b0});
        end
        push_random((len <= 40) ? len + $urandom_range(0, 4) : $urandom_range(20, 40));
      end else begin
        if ($urandom_range(0, 3) == 0) write_reg(CfgBodyLength, $urandom);
        write_reg(CfgCodingMode, {31'($urandom), 1'b1});
        if (kind < 80) begin
          build_chunked($urandom_range(0, 3) != 0);
        end else if (kind < 88) begin
          repeat ($urandom_range(20, 40)) body_q.push_back(noise_byte());
        end else begin
          // large chunk size, sometimes one digit too many
          body_q.push_back(hex_char(4'($urandom_range(1, 15)), $urandom_range(0, 1)));
          repeat ($urandom_range(7, 8)) begin
            body_q.push_back(hex_char(4'($urandom), $urandom_range(0, 1)));
          end
          if ($urandom_range(0, 1)) body_q.push_back(ChSemi);
          push_crlf();
          push_random($urandom_range(5, 20));
        end
      end
      random_sent += body_q.size();
      send_queue();
    end
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
